[design/assert_macros.svh]
// assertion helpers; every use expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sld assertion failed");

// next-cycle implication, checked outside reset
`define SLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sld assertion failed");

`endif

[design/sld_pkg.sv]
`default_nettype none

package sld_pkg;

  // frame status codes carried by the result word
  typedef enum logic [1:0] {
    FS_NONE     = 2'd0,
    FS_LEN_ERR  = 2'd1,
    FS_NO_BRACE = 2'd2,
    FS_GOOD     = 2'd3
  } frame_status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST   = 2'd0,
    CFG_SYNC_SECOND  = 2'd1,
    CFG_LENGTH_LIMIT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  localparam logic [7:0]  SYNC_FIRST_RST   = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND_RST  = 8'h5A;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd8191;

  // text scanner view after the current byte
  typedef struct packed {
    logic        lead_good;
    logic        seq_found;
    logic [31:0] seq_value;
  } scan_info_t;

endpackage

`default_nettype wire

[design/sld_if.sv]
`default_nettype none

// received byte channel
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface sld_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;
  logic        seq_found;
  logic [31:0] seq_value;
  logic        ack_request;
  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_status, output frame_length,
                  output seq_found, output seq_value, output ack_request,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_index, input frame_status, input frame_length,
                input seq_found, input seq_value, input ack_request,
                output ready);
endinterface

// configuration write channel
interface sld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/sync_length_deframer_seq_extract_top.sv]
`default_nettype none

// Byte deframer: hunts for two sync bytes, reads a 16-bit little-endian
// length and passes that many payload bytes through while checking that the
// text opens with a brace and parsing the first "seq" number. Every accepted
// byte gives exactly one result word; the last payload byte of a frame also
// carries the frame status, length, seq and ack request, and a second length
// byte that fails the length check carries FS_LEN_ERR. Throughput is one byte
// per clock while the result register is free: a byte is held in the input
// register, decoded by the framing and text-scan logic, and written into the
// result register once that register is free. The input keeps flowing while a
// result waits as long as the result register frees up. Configuration writes
// are always taken and apply at once; write them only while no bytes are in
// flight.
module sync_length_deframer_seq_extract_top (
  input wire logic  clk,
  input wire logic  rst,
  sld_in_if.sink    rx,
  sld_out_if.source res,
  sld_cfg_if.sink   cfg
);
  import sld_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD
  } phase_t;

  logic [7:0]  sync_first, sync_second;
  logic [15:0] length_limit;

  phase_t      phase, phase_next;
  logic [15:0] exp_len, exp_len_next;
  logic [15:0] pos, pos_next;

  logic        s0_valid;
  logic [7:0]  s0_byte;
  logic        out_free, advance;

  logic        scan_step, scan_clear;
  scan_info_t  info;

  logic [15:0] len_word, pos_inc;
  logic        len_ok;
  logic        r_pv, r_found, r_ack;
  logic [7:0]  r_byte;
  logic [15:0] r_index, r_len;
  logic [1:0]  r_status;
  logic [31:0] r_seq;
  logic        found_now;

  assign out_free = !res.valid || res.ready;
  assign advance  = s0_valid && out_free;
  assign rx.ready = !s0_valid || out_free;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= SYNC_FIRST_RST;
      sync_second  <= SYNC_SECOND_RST;
      length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_SYNC_FIRST:   sync_first <= cfg.data[7:0];
        CFG_SYNC_SECOND:  sync_second <= cfg.data[7:0];
        CFG_LENGTH_LIMIT: length_limit <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) s0_byte <= rx.rx_byte;
  end

  // scanner controls, kept apart from the decode that reads its view
  assign scan_clear = advance && (phase == PH_LEN2) && len_ok;
  assign scan_step  = advance && (phase != PH_SYNC1) && (phase != PH_SYNC2) &&
                      (phase != PH_LEN1) && (phase != PH_LEN2);

  sld_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .step  (scan_step),
    .clear (scan_clear),
    .data  (s0_byte),
    .info  (info)
  );

  assign len_word  = {s0_byte, exp_len[7:0]};
  assign len_ok    = (len_word != 16'd0) && (len_word <= length_limit);
  assign pos_inc   = pos + 16'd1;
  assign found_now = info.lead_good && info.seq_found;

  // framing decode for the byte in the input register
  always_comb begin
    phase_next   = phase;
    exp_len_next = exp_len;
    pos_next     = pos;
    r_pv         = 1'b0;
    r_byte       = 8'd0;
    r_index      = 16'd0;
    r_status     = FS_NONE;
    r_len        = 16'd0;
    r_found      = 1'b0;
    r_seq        = 32'd0;
    r_ack        = 1'b0;
    if (advance) begin
      unique case (phase)
        PH_SYNC1: begin
          if (s0_byte == sync_first) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (s0_byte == sync_second) phase_next = PH_LEN1;
          else if (s0_byte == sync_first) phase_next = PH_SYNC2;
          else phase_next = PH_SYNC1;
        end
        PH_LEN1: begin
          exp_len_next = {8'd0, s0_byte};
          phase_next   = PH_LEN2;
        end
        PH_LEN2: begin
          pos_next = 16'd0;
          if (!len_ok) begin
            r_status     = FS_LEN_ERR;
            phase_next   = PH_SYNC1;
            exp_len_next = 16'd0;
          end else begin
            exp_len_next = len_word;
            phase_next   = PH_PAYLOAD;
          end
        end
        default: begin
          r_pv      = 1'b1;
          r_byte    = s0_byte;
          r_index   = pos;
          pos_next  = pos_inc;
          if (pos_inc >= exp_len) begin
            r_status     = info.lead_good ? FS_GOOD : FS_NO_BRACE;
            r_len        = exp_len;
            r_found      = found_now;
            r_seq        = found_now ? info.seq_value : 32'd0;
            r_ack        = found_now && (info.seq_value != 32'd0);
            phase_next   = PH_SYNC1;
            exp_len_next = 16'd0;
            pos_next     = 16'd0;
          end
        end
      endcase
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SYNC1;
      exp_len <= 16'd0;
      pos     <= 16'd0;
    end else begin
      phase   <= phase_next;
      exp_len <= exp_len_next;
      pos     <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.payload_valid <= r_pv;
      res.payload_byte  <= r_byte;
      res.payload_index <= r_index;
      res.frame_status  <= r_status;
      res.frame_length  <= r_len;
      res.seq_found     <= r_found;
      res.seq_value     <= r_seq;
      res.ack_request   <= r_ack;
    end
  end

  // checks
  `SLD_ASSERT_NOW(a_seq_only_good, res.valid && res.seq_found, res.frame_status == FS_GOOD)
  `SLD_ASSERT_NOW(a_ack_needs_seq, res.valid && res.ack_request,
                  res.seq_found && (res.seq_value != 32'd0))
  `SLD_ASSERT_NOW(a_len_err_no_payload, res.valid && (res.frame_status == FS_LEN_ERR),
                  !res.payload_valid)
  `SLD_ASSERT_NEXT(a_stage_holds, s0_valid && !out_free, s0_valid && $stable(s0_byte))

endmodule

`default_nettype wire

[design/sld_scan.sv]
`default_nettype none

module sld_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              clear,
  input  wire logic [7:0]        data,
  output sld_pkg::scan_info_t    info
);
  import sld_pkg::*;

  typedef enum logic [1:0] {
    LEAD_PENDING,
    LEAD_GOOD,
    LEAD_BAD
  } lead_t;

  typedef enum logic [2:0] {
    VP_KEY,
    VP_PRECOLON,
    VP_POSTCOLON,
    VP_DIGITS,
    VP_FOUND,
    VP_FAILED
  } value_phase_t;

  localparam logic [2:0] KeyLen = 3'd5;

  logic         ended, ended_next;
  lead_t        lead, lead_next;
  logic [2:0]   key_cnt, key_cnt_next;
  value_phase_t vphase, vphase_next;
  logic [31:0]  acc, acc_next;
  logic         digit, digit_next;

  logic         is_space, is_digit;
  logic [3:0]   digit_val;
  logic [7:0]   key_char;

  // "seq" with its quotes
  function automatic logic [7:0] key_at(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'h22;
      3'd1: ch = 8'h73;
      3'd2: ch = 8'h65;
      3'd3: ch = 8'h71;
      3'd4: ch = 8'h22;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  assign is_space  = (data == 8'h20) || (data == 8'h09) || (data == 8'h0D) || (data == 8'h0A);
  assign is_digit  = (data >= 8'h30) && (data <= 8'h39);
  assign digit_val = data[3:0];
  assign key_char  = key_at(key_cnt);

  // next text state for the current byte
  always_comb begin
    ended_next   = ended;
    lead_next    = lead;
    key_cnt_next = key_cnt;
    vphase_next  = vphase;
    acc_next     = acc;
    digit_next   = digit;
    if (clear) begin
      ended_next   = 1'b0;
      lead_next    = LEAD_PENDING;
      key_cnt_next = 3'd0;
      vphase_next  = VP_KEY;
      acc_next     = 32'd0;
      digit_next   = 1'b0;
    end else if (step && !ended) begin
      if (data == 8'h00) begin
        ended_next = 1'b1;
      end else begin
        if (lead == LEAD_PENDING && !is_space) begin
          lead_next = (data == 8'h7B) ? LEAD_GOOD : LEAD_BAD;
        end
        unique case (vphase)
          VP_KEY: begin
            if (key_cnt < KeyLen && data == key_char) begin
              key_cnt_next = key_cnt + 3'd1;
              if (key_cnt_next == KeyLen) vphase_next = VP_PRECOLON;
            end else begin
              key_cnt_next = (data == key_at(3'd0)) ? 3'd1 : 3'd0;
            end
          end
          VP_PRECOLON: begin
            if (data == 8'h3A) vphase_next = VP_POSTCOLON;
            else if (!is_space) vphase_next = VP_FAILED;
          end
          VP_POSTCOLON: begin
            if (is_digit) begin
              acc_next    = {28'd0, digit_val};
              digit_next  = 1'b1;
              vphase_next = VP_DIGITS;
            end else if (!is_space) begin
              vphase_next = VP_FAILED;
            end
          end
          VP_DIGITS: begin
            // times ten as two shifts
            if (is_digit) acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, digit_val};
            else vphase_next = VP_FOUND;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ended   <= 1'b0;
      lead    <= LEAD_PENDING;
      key_cnt <= 3'd0;
      vphase  <= VP_KEY;
      acc     <= 32'd0;
      digit   <= 1'b0;
    end else begin
      ended   <= ended_next;
      lead    <= lead_next;
      key_cnt <= key_cnt_next;
      vphase  <= vphase_next;
      acc     <= acc_next;
      digit   <= digit_next;
    end
  end

  assign info.lead_good = (lead_next == LEAD_GOOD);
  assign info.seq_found = ((vphase_next == VP_DIGITS) || (vphase_next == VP_FOUND)) && digit_next;
  assign info.seq_value = acc_next;

endmodule

`default_nettype wire
